// ----- rtl/lspg_pkg.sv -----
package lspg_pkg;

   // time base of the patterns, in milliseconds
   localparam int unsigned PERIOD_MS = 2000;
   localparam int unsigned READY_MS  = 3000;
   localparam int unsigned STEP_MS   = 1000;
   localparam int unsigned BLINK_MS  = 500;

   localparam int unsigned PHASE_W = 11;
   localparam int unsigned RUN_W   = 12;

   // breathing table covers the folded phase 0 .. PERIOD_MS / 2
   localparam int unsigned BREATH_ENTRIES = PERIOD_MS / 2 + 1;
   localparam int unsigned BREATH_IDX_W   = $clog2(BREATH_ENTRIES);

   // register reset values
   localparam logic [7:0] DIM_RESET  = 8'h40;
   localparam logic [7:0] TEST_RESET = 8'h30;

   // fixed point constants of the level curve
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef enum logic [2:0] {
      MODE_BOOTING = 3'd0,
      MODE_READY   = 3'd1,
      MODE_FAILED  = 3'd2,
      MODE_CAUTION = 3'd3,
      MODE_TEST    = 3'd4,
      MODE_OFF     = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE = 2'd0,
      CSR_DIM  = 2'd1,
      CSR_TEST = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [RUN_W-1:0]   run;
   } time_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef logic [7:0] breath_rom_type [BREATH_ENTRIES];

   // raised cosine levels, sin^2 by a Q30 Taylor series to x^11
   function automatic breath_rom_type build_breath_rom(int unsigned peak);
      breath_rom_type rom;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    t;
      logic [63:0]    s;
      logic [63:0]    r;
      logic [63:0]    lv;
      for (int p = 0; p < BREATH_ENTRIES; p++) begin
         x  = (PI_Q30 * 64'(p)) / PERIOD_MS;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - x2 / 110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
         r  = (s * s) >> 30;
         lv = ((64'(peak) * r) + (Q30_ONE >> 1)) >> 30;
         rom[p] = lv[7:0];
      end
      return rom;
   endfunction

endpackage

// ----- rtl/lspg_timer.sv -----
module lspg_timer
   import lspg_pkg::*;
#(
   parameter int unsigned TICK_MS = 50
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   output time_type now,
   output time_type next
);

   localparam logic [RUN_W-1:0] TICK    = RUN_W'(TICK_MS);
   localparam logic [RUN_W-1:0] PERIOD  = RUN_W'(PERIOD_MS);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(READY_MS);

   time_type         time_ff;
   time_type         time_in;
   logic [RUN_W-1:0] phase_sum;
   logic [RUN_W-1:0] run_sum;

   // phase wraps at the period, run saturates at the ready time
   always_comb begin
      phase_sum = {1'b0, time_ff.phase} + TICK;
      run_sum   = time_ff.run + TICK;
      if (phase_sum >= PERIOD) begin
         time_in.phase = PHASE_W'(phase_sum - PERIOD);
      end else begin
         time_in.phase = phase_sum[PHASE_W-1:0];
      end
      if (run_sum > RUN_MAX) begin
         time_in.run = RUN_MAX;
      end else begin
         time_in.run = run_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (advance) begin
         time_ff <= time_in;
      end
   end

   assign now  = time_ff;
   assign next = time_in;

endmodule

// ----- rtl/lspg_breath.sv -----
module lspg_breath
   import lspg_pkg::*;
#(
   parameter int unsigned BREATH_PEAK = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [PHASE_W-1:0] next_phase,
   output logic [7:0]         level
);

   localparam breath_rom_type BREATH_ROM = build_breath_rom(BREATH_PEAK);
   localparam logic [PHASE_W-1:0] HALF   = PHASE_W'(PERIOD_MS / 2);
   localparam logic [PHASE_W-1:0] PERIOD = PHASE_W'(PERIOD_MS);

   logic [PHASE_W-1:0]      folded;
   logic [BREATH_IDX_W-1:0] rom_addr;
   logic [7:0]              level_ff;

   // fold the next phase onto the rising half of the curve
   always_comb begin
      if (next_phase <= HALF) begin
         folded = next_phase;
      end else begin
         folded = PERIOD - next_phase;
      end
      rom_addr = folded[BREATH_IDX_W-1:0];
   end

   // registered table read of the next phase, so the level stays in step with the phase counter
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= BREATH_ROM[0];
      end else if (advance) begin
         level_ff <= BREATH_ROM[rom_addr];
      end
   end

   assign level = level_ff;

endmodule

// ----- rtl/lspg_pattern.sv -----
module lspg_pattern
   import lspg_pkg::*;
(
   input  mode_type   mode,
   input  logic [7:0] dim_level,
   input  logic [7:0] test_level,
   input  time_type   now,
   input  logic [7:0] level,
   output color_type  color,
   output logic       over
);

   localparam logic [PHASE_W-1:0] BLINK   = PHASE_W'(BLINK_MS);
   localparam logic [PHASE_W-1:0] STEP_P  = PHASE_W'(STEP_MS);
   localparam logic [PHASE_W-1:0] STEP_P3 = PHASE_W'(STEP_MS + BLINK_MS);
   localparam logic [RUN_W-1:0]   STEP1   = RUN_W'(STEP_MS);
   localparam logic [RUN_W-1:0]   STEP2   = RUN_W'(2 * STEP_MS);
   localparam logic [RUN_W-1:0]   STEP3   = RUN_W'(3 * STEP_MS);
   localparam logic [RUN_W-1:0]   READY   = RUN_W'(READY_MS);

   logic [16:0] third_prod;
   logic [7:0]  dim_third;
   logic        blink_on;

   // divide by three as multiply by 171 and shift, exact for 8 bits
   always_comb begin
      third_prod = 17'(dim_level) * 17'd171;
      dim_third  = 8'(third_prod >> 9);
      blink_on   = (now.phase < BLINK) || ((now.phase >= STEP_P) && (now.phase < STEP_P3));
   end

   // color and end condition of the selected pattern
   always_comb begin
      color = '0;
      over  = 1'b0;
      case (mode)
         MODE_BOOTING: begin
            color.blue = level;
         end
         MODE_READY: begin
            color.green = dim_level;
            over        = (now.run >= READY);
         end
         MODE_FAILED: begin
            if (blink_on) begin
               color.red = dim_level;
            end
         end
         MODE_CAUTION: begin
            if (now.phase < STEP_P) begin
               color.red   = dim_level;
               color.green = dim_third;
            end
         end
         MODE_TEST: begin
            if (now.run >= STEP3) begin
               over = 1'b1;
            end else if (now.run >= STEP2) begin
               color.blue = test_level;
            end else if (now.run >= STEP1) begin
               color.green = test_level;
            end else begin
               color.red = test_level;
            end
         end
         default: begin
            over = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/led_status_pattern_generator.sv -----
// LED status pattern generator, one result per tick item.
// A result is registered and appears on rsp in the cycle after its tick transfer.
// Throughput: one tick per cycle; ticks stall only while a result is held.
// Breathing levels come from a registered table read one tick ahead.
// Reset (synchronous, active high) clears counters, flags and the output valid,
// and sets mode off, dim level 0x40, test level 0x30.
module led_status_pattern_generator
   import lspg_pkg::*;
#(
   parameter int unsigned TICK_MS     = 50,
   parameter int unsigned BREATH_PEAK = 63
) (
   input  logic        clock,
   input  logic        reset,
   // tick input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] stop, [7:1] zero
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [24] changed, [25] done_res, [31:26] zero
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   mode_type    mode_ff;
   logic [7:0]  dim_ff;
   logic [7:0]  test_ff;
   logic        finished_ff;
   color_type   shown_ff;
   logic        shown_valid_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic        accept;
   logic        advance;
   logic        ending;
   time_type    now;
   time_type    next;
   logic [7:0]  level;
   color_type   frame_color;
   logic        over;
   color_type   out_color;
   logic        changed;

   lspg_timer #(.TICK_MS(TICK_MS)) u_timer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .now     (now),
      .next    (next)
   );

   lspg_breath #(.BREATH_PEAK(BREATH_PEAK)) u_breath (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .next_phase (next.phase),
      .level      (level)
   );

   lspg_pattern u_pattern (
      .mode       (mode_ff),
      .dim_level  (dim_ff),
      .test_level (test_ff),
      .now        (now),
      .level      (level),
      .color      (frame_color),
      .over       (over)
   );

   // register writes, unknown index ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         dim_ff  <= DIM_RESET;
         test_ff <= TEST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MODE: mode_ff <= mode_type'(csr_data[2:0]);
            CSR_DIM:  dim_ff  <= csr_data;
            CSR_TEST: test_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // tick handling
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ending     = !finished_ff && (req_tdata[0] || over);
   assign advance    = accept && !finished_ff && !ending;

   always_comb begin
      if (finished_ff || ending) begin
         out_color = '0;
         changed   = !finished_ff;
      end else begin
         out_color = frame_color;
         changed   = !shown_valid_ff || (frame_color != shown_ff);
      end
   end

   // pattern state
   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff    <= 1'b0;
         shown_ff       <= '0;
         shown_valid_ff <= 1'b0;
      end else if (accept && !finished_ff) begin
         finished_ff    <= ending;
         shown_ff       <= out_color;
         shown_valid_ff <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {6'd0, (finished_ff || ending), changed,
                         out_color.blue, out_color.green, out_color.red};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/lspg_checker.sv -----
module lspg_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic done_seen_ff;

   // remember a transfer that reported the end of the pattern
   always_ff @(posedge clock) begin
      if (reset) begin
         done_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[25]) begin
         done_seen_ff <= 1'b1;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // ticks are refused only while a result waits
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("tick refused with empty output");

   // a finished pattern is dark
   a_done_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> rsp_tdata[23:0] == 24'd0)
      else $error("done result not dark");

   // after the end every result is dark, unchanged and done
   a_stay_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && done_seen_ff |-> rsp_tdata[25] && !rsp_tdata[24])
      else $error("result after end not quiet");

endmodule

bind led_status_pattern_generator lspg_assertions u_lspg_assertions (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/lspg_checker.sv -----
`timescale 1ns / 100ps

module lspg_checker
   import lspg_pkg::*;
#(
   parameter int unsigned TICK_MS     = 50,
   parameter int unsigned BREATH_PEAK = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] stop, [7:1] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [24] changed, [25] done_res, [31:26] zero
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          waiting_count
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       changed;
      logic       done;
   } frame_type;

   // register copies
   logic [2:0]         mode_reg;
   logic [7:0]         dim_reg;
   logic [7:0]         test_reg;

   // pattern state copies
   logic [PHASE_W-1:0] phase_ms;
   logic [RUN_W-1:0]   run_ms;
   logic [23:0]        shown_rgb;
   logic               shown_valid;
   logic               finished;

   frame_type          frames_due [$];

   // sin^2 of the folded phase, Q30 Taylor series, scaled to the peak
   function automatic logic [7:0] raised_cosine_level(input int unsigned ph);
      logic [63:0] folded;
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] poly;
      logic [63:0] sine;
      logic [63:0] sine_sq;
      logic [63:0] scaled;
      folded = (ph <= STEP_MS) ? 64'(ph) : 64'(PERIOD_MS - ph);
      if (folded > 64'(STEP_MS)) begin
         folded = 64'(STEP_MS);
      end
      angle    = (PI_Q30 * folded) / 64'(PERIOD_MS);
      angle_sq = (angle * angle) >> 30;
      poly     = Q30_ONE - angle_sq / 64'd110;
      poly     = Q30_ONE - ((angle_sq * poly) >> 30) / 64'd72;
      poly     = Q30_ONE - ((angle_sq * poly) >> 30) / 64'd42;
      poly     = Q30_ONE - ((angle_sq * poly) >> 30) / 64'd20;
      poly     = Q30_ONE - ((angle_sq * poly) >> 30) / 64'd6;
      sine     = (angle * poly) >> 30;
      if (sine > Q30_ONE) begin
         sine = Q30_ONE;
      end
      sine_sq = (sine * sine) >> 30;
      scaled  = ((64'(BREATH_PEAK) * sine_sq) + (Q30_ONE >> 1)) >> 30;
      return scaled[7:0];
   endfunction

   // one tick of the pattern: colour at the current time, then time advances while the pattern runs
   task automatic play_tick(input logic stop, output frame_type res);
      logic [23:0] rgb;
      logic [7:0]  dim_third;
      logic        over;
      logic        changed;
      int unsigned step;
      int unsigned run_next;
      rgb       = '0;
      over      = 1'b0;
      changed   = 1'b0;
      dim_third = dim_reg / 8'd3;
      step      = run_ms / STEP_MS;
      case (mode_reg)
         MODE_BOOTING: rgb = {16'h0000, raised_cosine_level(phase_ms)};
         MODE_READY: begin
            rgb  = {8'h00, dim_reg, 8'h00};
            over = (run_ms >= READY_MS);
         end
         MODE_FAILED: begin
            if ((phase_ms % STEP_MS) < BLINK_MS) begin
               rgb = {dim_reg, 16'h0000};
            end
         end
         MODE_CAUTION: begin
            if (phase_ms < STEP_MS) begin
               rgb = {dim_reg, dim_third, 8'h00};
            end
         end
         MODE_TEST: begin
            if (step >= 3) begin
               over = 1'b1;
            end else if (step == 0) begin
               rgb = {test_reg, 16'h0000};
            end else if (step == 1) begin
               rgb = {8'h00, test_reg, 8'h00};
            end else begin
               rgb = {16'h0000, test_reg};
            end
         end
         default: over = 1'b1;
      endcase

      if (finished) begin
         rgb = '0;
      end else if (stop || over) begin
         rgb         = '0;
         changed     = 1'b1;
         finished    = 1'b1;
         shown_rgb   = '0;
         shown_valid = 1'b1;
      end else begin
         changed     = !shown_valid || (rgb != shown_rgb);
         shown_rgb   = rgb;
         shown_valid = 1'b1;
         phase_ms    = PHASE_W'((phase_ms + TICK_MS) % PERIOD_MS);
         run_next    = run_ms + TICK_MS;
         run_ms      = RUN_W'((run_next > READY_MS) ? READY_MS : run_next);
      end

      res.red     = rgb[23:16];
      res.green   = rgb[15:8];
      res.blue    = rgb[7:0];
      res.changed = changed;
      res.done    = finished;
   endtask

   // watch all three channels, sampled at the rising edge
   always @(posedge clock) begin : monitor
      frame_type got;
      frame_type want;
      if (reset) begin
         mode_reg    = MODE_OFF;
         dim_reg     = DIM_RESET;
         test_reg    = TEST_RESET;
         phase_ms    = '0;
         run_ms      = '0;
         shown_rgb   = '0;
         shown_valid = 1'b0;
         finished    = 1'b0;
         frames_due.delete();
         fail_count  = 0;
      end else begin
         // result transfer against the oldest expected frame
         if (rsp_tvalid && rsp_tready) begin
            got.red     = rsp_tdata[7:0];
            got.green   = rsp_tdata[15:8];
            got.blue    = rsp_tdata[23:16];
            got.changed = rsp_tdata[24];
            got.done    = rsp_tdata[25];
            if (frames_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected result: rgb %h %h %h changed %b done %b",
                           got.red, got.green, got.blue, got.changed, got.done);
               end
            end else begin
               want = frames_due.pop_front();
               if (got.red != want.red || got.green != want.green ||
                   got.blue != want.blue || got.changed != want.changed ||
                   got.done != want.done || rsp_tdata[31:26] != '0) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("result mismatch: rgb %h %h %h changed %b done %b",
                              got.red, got.green, got.blue, got.changed, got.done,
                              " pad %h, expected rgb %h %h %h changed %b done %b",
                              rsp_tdata[31:26], want.red, want.green, want.blue,
                              want.changed, want.done);
                  end
               end
            end
         end

         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE: mode_reg = csr_data[2:0];
               CSR_DIM:  dim_reg  = csr_data;
               CSR_TEST: test_reg = csr_data;
               default: ;
            endcase
         end

         // tick transfer
         if (req_tvalid && req_tready) begin
            play_tick(req_tdata[0], want);
            frames_due.push_back(want);
         end
      end
      waiting_count = frames_due.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import lspg_pkg::*;

   localparam int unsigned TICK_MS     = 50;
   localparam int unsigned BREATH_PEAK = 63;

   // ticks until the run counter saturates
   localparam int RUN_TICKS   = READY_MS / TICK_MS;
   localparam int TICK_TARGET = 630;
   localparam int QUIET_LIMIT = 2000;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;
   localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   // stop bit placement within a burst of ticks
   localparam int STOP_NONE = 0;
   localparam int STOP_LAST = 1;
   localparam int STOP_ANY  = 2;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = 2'd0;
   logic [7:0]  csr_data   = 8'h00;

   int          fail_count;
   int          waiting_count;
   int          ticks_sent = 0;
   int          quiet_cycles = 0;
   bit          no_idle = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   led_status_pattern_generator #(
      .TICK_MS     (TICK_MS),
      .BREATH_PEAK (BREATH_PEAK)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lspg_checker #(
      .TICK_MS     (TICK_MS),
      .BREATH_PEAK (BREATH_PEAK)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 17);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [7:0] pick_level();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one register write transfer, starts and ends on a falling edge
   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mode write with random unused upper bits
   task automatic write_mode(input logic [2:0] mode);
      write_reg(CSR_MODE, {5'($urandom_range(31)), mode});
   endtask

   // burst of tick transfers with random source gaps
   task automatic send_ticks(input int count, input int stop_kind);
      logic stop;
      for (int i = 0; i < count; i++) begin
         while (!no_idle && $urandom_range(99) < 17) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         case (stop_kind)
            STOP_LAST: stop = (i == count - 1);
            STOP_ANY:  stop = 1'($urandom_range(1));
            default:   stop = 1'b0;
         endcase
         req_tvalid <= 1'b1;
         req_tdata  <= {7'b0, stop};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         ticks_sent++;
         no_idle = (ticks_sent >= 300) && (ticks_sent < 420);
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (waiting_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [2:0] mode_pick;
      int         burst;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: unknown index, level extremes, test, ready, failed, caution and booting before saturation
      write_reg(CSR_UNUSED, 8'($urandom_range(255)));
      write_reg(CSR_DIM, 8'hFF);
      write_reg(CSR_TEST, 8'h00);
      write_mode(MODE_TEST);
      send_ticks(2, STOP_NONE);
      wait_drained();
      write_reg(CSR_TEST, 8'hFF);
      send_ticks(1, STOP_NONE);
      wait_drained();
      write_mode(MODE_READY);
      send_ticks(2, STOP_NONE);
      wait_drained();
      write_reg(CSR_DIM, 8'h00);
      send_ticks(1, STOP_NONE);
      wait_drained();
      write_mode(MODE_FAILED);
      write_reg(CSR_DIM, 8'hFF);
      send_ticks(2, STOP_NONE);
      wait_drained();
      write_mode(MODE_CAUTION);
      send_ticks(2, STOP_NONE);
      wait_drained();
      write_mode(MODE_BOOTING);
      send_ticks(3, STOP_NONE);

      // random phases, ready and test only while they cannot finish
      while (ticks_sent < TICK_TARGET) begin
         wait_drained();
         burst = $urandom_range(1, 30);
         if (ticks_sent < RUN_TICKS && $urandom_range(2) == 0) begin
            mode_pick = $urandom_range(1) ? MODE_READY : MODE_TEST;
            if (burst > RUN_TICKS - ticks_sent) begin
               burst = RUN_TICKS - ticks_sent;
            end
         end else begin
            case ($urandom_range(2))
               0:       mode_pick = MODE_BOOTING;
               1:       mode_pick = MODE_FAILED;
               default: mode_pick = MODE_CAUTION;
            endcase
         end
         if ($urandom_range(7) == 0) begin
            write_reg(CSR_UNUSED, 8'($urandom_range(255)));
         end
         if ($urandom_range(1)) begin
            write_reg(CSR_DIM, pick_level());
         end
         write_mode(mode_pick);
         if ($urandom_range(1)) begin
            write_reg(CSR_TEST, pick_level());
         end
         send_ticks(burst, STOP_NONE);
      end

      // end the pattern by stop or by a finishing mode, then ticks after it
      wait_drained();
      if ($urandom_range(4) == 0) begin
         send_ticks($urandom_range(1, 6), STOP_LAST);
      end else begin
         case ($urandom_range(3))
            0:       mode_pick = MODE_READY;
            1:       mode_pick = MODE_TEST;
            2:       mode_pick = MODE_OFF;
            default: mode_pick = $urandom_range(1) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
         endcase
         write_mode(mode_pick);
      end
      send_ticks(13, STOP_ANY);

      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && waiting_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
